/* design/sdiv64_pkg.sv */
// Shared constants, types and the division step function for the signed 64-bit divider.
package sdiv64_pkg;

  localparam int DATA_WIDTH = 64;
  localparam int IO_WIDTH   = 64;
  localparam int Q_DEPTH    = 4;
  localparam int Q_PTR_W    = $clog2(Q_DEPTH);
  localparam int Q_CNT_W    = $clog2(Q_DEPTH + 1);

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_DIV_ZERO = 2'd1,
    ST_OVERFLOW = 2'd2,
    ST_UNUSED   = 2'd3
  } status_t;

  typedef struct packed {
    status_t               st;
    logic                  q_neg;
    logic                  r_neg;
    logic [DATA_WIDTH-1:0] a;
    logic [DATA_WIDTH-1:0] d;
    logic [DATA_WIDTH-1:0] r;
    logic [DATA_WIDTH-1:0] q;
  } work_t;

  function automatic work_t div_step(input work_t w);
    work_t                 o;
    logic [DATA_WIDTH:0]   t;
    o = w;
    t = {w.r, w.q[DATA_WIDTH-1]} - {1'b0, w.d};
    if (!t[DATA_WIDTH]) begin
      o.r = t[DATA_WIDTH-1:0];
      o.q = {w.q[DATA_WIDTH-2:0], 1'b1};
    end else begin
      o.r = {w.r[DATA_WIDTH-2:0], w.q[DATA_WIDTH-1]};
      o.q = {w.q[DATA_WIDTH-2:0], 1'b0};
    end
    return o;
  endfunction

endpackage

/* design/sdiv64_front.sv */
// Front stage: capture operand pairs, classify special cases, form magnitudes.
module sdiv64_front import sdiv64_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [IO_WIDTH-1:0] dividend,
  input  logic [IO_WIDTH-1:0] divisor,
  output logic                f_valid,
  input  logic                f_ready,
  output work_t               f_data
);

  logic                  valid_r, valid_nxt;
  work_t                 data_r, data_nxt;
  logic [DATA_WIDTH-1:0] a, b;
  logic                  an, bn;
  logic [DATA_WIDTH-1:0] min_val;

  assign in_ready = !valid_r || f_ready;
  assign f_valid  = valid_r;
  assign f_data   = data_r;

  always_comb begin
    a       = dividend[DATA_WIDTH-1:0];
    b       = divisor[DATA_WIDTH-1:0];
    an      = a[DATA_WIDTH-1];
    bn      = b[DATA_WIDTH-1];
    min_val = {1'b1, {(DATA_WIDTH-1){1'b0}}};
    data_nxt.a     = a;
    data_nxt.d     = bn ? (~b + 1'b1) : b;
    data_nxt.q     = an ? (~a + 1'b1) : a;
    data_nxt.r     = '0;
    data_nxt.q_neg = an ^ bn;
    data_nxt.r_neg = an;
    if (b == '0) begin
      data_nxt.st = ST_DIV_ZERO;
    end else if (a == min_val && b == '1) begin
      data_nxt.st = ST_OVERFLOW;
    end else begin
      data_nxt.st = ST_OK;
    end
    valid_nxt = in_ready ? in_valid : valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
    if (in_valid && in_ready) begin
      data_r <= data_nxt;
    end
  end

endmodule

/* design/sdiv64_queue.sv */
// Short queue between the front stage and the divider pipeline.
module sdiv64_queue import sdiv64_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  wr_valid,
  output logic  wr_ready,
  input  work_t wr_data,
  output logic  rd_valid,
  input  logic  rd_ready,
  output work_t rd_data
);

  work_t                mem_r [Q_DEPTH];
  logic [Q_PTR_W-1:0]   wp_r, wp_nxt, rp_r, rp_nxt;
  logic [Q_CNT_W-1:0]   cnt_r, cnt_nxt;
  logic                 push, pop;

  assign wr_ready = cnt_r != Q_CNT_W'(Q_DEPTH);
  assign rd_valid = cnt_r != '0;
  assign rd_data  = mem_r[rp_r];
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_valid && rd_ready;

  always_comb begin
    wp_nxt  = push ? wp_r + 1'b1 : wp_r;
    rp_nxt  = pop ? rp_r + 1'b1 : rp_r;
    cnt_nxt = cnt_r + Q_CNT_W'(push) - Q_CNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
    if (push) begin
      mem_r[wp_r] <= wr_data;
    end
  end

endmodule

/* design/sdiv64_back.sv */
// Back end: one quotient bit per stage, sign fixup and output register.
module sdiv64_back import sdiv64_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                b_valid,
  output logic                b_ready,
  input  work_t               b_data,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [IO_WIDTH-1:0] quotient,
  output logic [IO_WIDTH-1:0] remainder_out,
  output status_t             status
);

  logic                  en;
  logic                  v_r   [DATA_WIDTH];
  work_t                 p_r   [DATA_WIDTH];
  logic                  ov_r, ov_nxt;
  logic [IO_WIDTH-1:0]   q_r, q_nxt, r_r, r_nxt;
  status_t               st_r, st_nxt;
  work_t                 last;
  logic [DATA_WIDTH-1:0] qv, rv;

  assign en            = !ov_r || out_ready;
  assign b_ready       = en;
  assign out_valid     = ov_r;
  assign quotient      = q_r;
  assign remainder_out = r_r;
  assign status        = st_r;

  always_comb begin
    last = div_step(p_r[DATA_WIDTH-1]);
    case (last.st)
      ST_DIV_ZERO: begin
        qv = '1;
        rv = last.a;
      end
      ST_OVERFLOW: begin
        qv = last.a;
        rv = '0;
      end
      default: begin
        qv = last.q_neg ? (~last.q + 1'b1) : last.q;
        rv = last.r_neg ? (~last.r + 1'b1) : last.r;
      end
    endcase
    q_nxt  = IO_WIDTH'($signed(qv));
    r_nxt  = IO_WIDTH'($signed(rv));
    st_nxt = last.st;
    ov_nxt = en ? v_r[DATA_WIDTH-1] : ov_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0;
      for (int i = 0; i < DATA_WIDTH; i++) begin
        v_r[i] <= 1'b0;
      end
    end else begin
      ov_r <= ov_nxt;
      if (en) begin
        v_r[0] <= b_valid;
        for (int i = 1; i < DATA_WIDTH; i++) begin
          v_r[i] <= v_r[i-1];
        end
      end
    end
    if (en) begin
      p_r[0] <= b_data;
      for (int i = 1; i < DATA_WIDTH; i++) begin
        p_r[i] <= div_step(p_r[i-1]);
      end
      q_r  <= q_nxt;
      r_r  <= r_nxt;
      st_r <= st_nxt;
    end
  end

endmodule

/* design/signed_divider_64_top.sv */
// Path: front stage register, queue, divider pipeline registers, output register.
// Throughput: one beat per cycle unless the output is held; one quotient bit per stage.
// The pipeline stalls as a whole only when the output register is held.
// Reset: synchronous active-low rst_n empties the front stage, queue and pipeline.
// Top level: signed 64-bit divider with stream ports.
module signed_divider_64_top import sdiv64_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [127:0] in_tdata,   // dividend[63:0], divisor[127:64]
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [127:0] out_tdata,  // quotient[63:0], remainder_out[127:64]
  output logic [1:0]   out_tuser   // status[1:0]
);

  logic    f_valid, f_ready, b_valid, b_ready;
  work_t   f_data, b_data;
  status_t st;

  sdiv64_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .dividend (in_tdata[63:0]),
    .divisor  (in_tdata[127:64]),
    .f_valid  (f_valid),
    .f_ready  (f_ready),
    .f_data   (f_data)
  );

  sdiv64_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_valid (f_valid),
    .wr_ready (f_ready),
    .wr_data  (f_data),
    .rd_valid (b_valid),
    .rd_ready (b_ready),
    .rd_data  (b_data)
  );

  sdiv64_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .b_valid       (b_valid),
    .b_ready       (b_ready),
    .b_data        (b_data),
    .out_valid     (out_tvalid),
    .out_ready     (out_tready),
    .quotient      (out_tdata[63:0]),
    .remainder_out (out_tdata[127:64]),
    .status        (st)
  );

  assign out_tuser = st;

endmodule
